// ----- hw/rtl/osq_pkg.sv -----
`default_nettype none

package osq_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 7;
  localparam int unsigned CmdW  = 4;
  localparam int unsigned StatW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_INS_HEAD = 4'd0,
    CMD_INS_TAIL = 4'd1,
    CMD_INS_POS  = 4'd2,
    CMD_DEL_HEAD = 4'd3,
    CMD_DEL_TAIL = 4'd4,
    CMD_DEL_POS  = 4'd5,
    CMD_FIND_FST = 4'd6,
    CMD_FIND_LST = 4'd7,
    CMD_COUNT    = 4'd8
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e          op;
    logic [WordW-1:0]  key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ordered_sequence_store_core.sv -----
`default_nettype none
// insert and delete: cells updated on accept, result valid the next cycle
// searches: compare in all cells on accept, then one cell per cycle in the scan unit,
//   result registered after the walk, output permitting; the scan walk sets the search rate
// a new item is taken once the controller is idle and the output register is free or drains
// reset (async, active low) empties the list and drops any pending result; cell words unreset
module ordered_sequence_store_core #(
  parameter int unsigned DEPTH = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // command item in
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // [6:0] position, [38:7] value, [39] zero
  input  wire  [3:0]  s_axis_tuser,   // [3:0] cmd
  // result item out
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [55:0] m_axis_tdata    // [1:0] status, [33:2] removed_value,
                                      // [40:34] found_position, [47:41] match_count,
                                      // [54:48] entry_count, [55] zero
);
  import osq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ((CW > PosW) ? CW : PosW) + 1;

  // input fields
  logic [PosW-1:0]  in_pos;
  logic [WordW-1:0] in_val;
  cmd_e             in_cmd;

  assign in_pos = s_axis_tdata[PosW-1:0];
  assign in_val = s_axis_tdata[PosW+WordW-1:PosW];
  assign in_cmd = cmd_e'(s_axis_tuser);

  // control state
  state_e        state_q, state_d;
  logic [CW-1:0] len_q, len_d;
  cmd_e          srch_cmd_q, srch_cmd_d;

  // output register
  logic             out_valid_q, out_valid_d;
  status_e          out_stat_q, out_stat_d;
  logic [WordW-1:0] out_rem_q, out_rem_d;
  logic [PosW-1:0]  out_found_q, out_found_d;
  logic [PosW-1:0]  out_match_q, out_match_d;
  logic [PosW-1:0]  out_count_q, out_count_d;

  logic accept, out_free, scan_load;

  // cell chain
  cell_ctrl_t       cell_ctrl;
  cell_op_e         op;
  logic [IW-1:0]    at;
  logic [WordW-1:0] words [DEPTH];
  logic [WordW-1:0] picks [DEPTH];
  logic [DEPTH-1:0] hits;
  logic [WordW-1:0] picked;

  // scan unit
  logic          scan_start, scan_busy;
  logic [CW-1:0] scan_first, scan_last, scan_cnt;

  // command decode
  status_e       dec_stat;
  logic          dec_del, dec_srch;
  logic [PW-1:0] pos_w, len_w;
  logic          full, empty;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign scan_load     = (state_q == ST_SCAN) && !scan_busy && out_free;

  assign pos_w = PW'(in_pos);
  assign len_w = PW'(len_q);
  assign full  = (len_q == CW'(DEPTH));
  assign empty = (len_q == '0);

  // decide cell operation, target slot and status for the item on the input
  always_comb begin
    op       = CELL_HOLD;
    at       = '0;
    dec_stat = STAT_OK;
    dec_del  = 1'b0;
    dec_srch = 1'b0;
    case (in_cmd)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        if (full) begin
          dec_stat = STAT_FULL;
        end else if (in_cmd == CMD_INS_HEAD) begin
          op = CELL_INS;
        end else if (in_cmd == CMD_INS_TAIL) begin
          op = CELL_INS;
          at = IW'(len_q);
        end else if (pos_w == '0 || pos_w > len_w + PW'(1)) begin
          dec_stat = STAT_BAD_POS;
        end else begin
          op = CELL_INS;
          at = IW'(pos_w - PW'(1));
        end
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
        if (empty) begin
          dec_stat = STAT_EMPTY;
        end else if (in_cmd == CMD_DEL_HEAD) begin
          op      = CELL_DEL;
          dec_del = 1'b1;
        end else if (in_cmd == CMD_DEL_TAIL) begin
          op      = CELL_DEL;
          dec_del = 1'b1;
          at      = IW'(len_q - CW'(1));
        end else if (pos_w == '0 || pos_w > len_w) begin
          dec_stat = STAT_BAD_POS;
        end else begin
          op      = CELL_DEL;
          dec_del = 1'b1;
          at      = IW'(pos_w - PW'(1));
        end
      end
      CMD_FIND_FST, CMD_FIND_LST, CMD_COUNT: begin
        dec_srch = 1'b1;
      end
      default: begin
        op = CELL_HOLD;
      end
    endcase
  end

  assign cell_ctrl.op  = accept ? op : CELL_HOLD;
  assign cell_ctrl.key = in_val;
  assign scan_start    = accept && dec_srch;

  // row of cells, entry 0 at the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] prev_w, next_w;
    if (i == 0) begin : g_head
      assign prev_w = in_val;
    end else begin : g_mid_prev
      assign prev_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_w = words[i];
    end else begin : g_mid_next
      assign next_w = words[i+1];
    end
    osq_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .at_i    (at),
      .len_i   (len_q),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .word_o  (words[i]),
      .match_o (hits[i]),
      .pick_o  (picks[i])
    );
  end

  // only the cell at the target slot drives its word; all others drive zero
  always_comb begin
    picked = '0;
    for (int i = 0; i < DEPTH; i++) begin
      picked = picked | picks[i];
    end
  end

  osq_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .hits_i  (hits),
    .len_i   (len_q),
    .busy_o  (scan_busy),
    .first_o (scan_first),
    .last_o  (scan_last),
    .count_o (scan_cnt)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (scan_start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // list length, search kind and output register
  always_comb begin
    len_d       = len_q;
    srch_cmd_d  = srch_cmd_q;
    out_valid_d = out_valid_q;
    out_stat_d  = out_stat_q;
    out_rem_d   = out_rem_q;
    out_found_d = out_found_q;
    out_match_d = out_match_q;
    out_count_d = out_count_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op == CELL_INS) begin
            len_d = len_q + CW'(1);
          end else if (op == CELL_DEL) begin
            len_d = len_q - CW'(1);
          end
          if (dec_srch) begin
            srch_cmd_d = in_cmd;
          end else begin
            out_valid_d = 1'b1;
            out_stat_d  = dec_stat;
            out_rem_d   = dec_del ? picked : '0;
            out_found_d = '0;
            out_match_d = '0;
            out_count_d = PosW'(len_d);
          end
        end
      end
      ST_SCAN: begin
        if (scan_load) begin
          out_valid_d = 1'b1;
          out_stat_d  = STAT_OK;
          out_rem_d   = '0;
          out_found_d = '0;
          out_match_d = '0;
          out_count_d = PosW'(len_q);
          if (srch_cmd_q == CMD_FIND_FST) begin
            out_found_d = PosW'(scan_first);
          end else if (srch_cmd_q == CMD_FIND_LST) begin
            out_found_d = PosW'(scan_last);
          end else begin
            out_match_d = PosW'(scan_cnt);
          end
        end
      end
      default: begin
        out_valid_d = out_valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    srch_cmd_q  <= srch_cmd_d;
    out_stat_q  <= out_stat_d;
    out_rem_q   <= out_rem_d;
    out_found_q <= out_found_d;
    out_match_q <= out_match_d;
    out_count_q <= out_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_match_q, out_found_q, out_rem_q,
                          out_stat_q};

endmodule

`default_nettype wire

// ----- hw/rtl/osq_cell.sv -----
`default_nettype none

module osq_cell #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX   = 0
) (
  input  wire                                 clk_i,
  input  osq_pkg::cell_ctrl_t                 ctrl_i,
  input  wire  [$clog2(DEPTH)-1:0]            at_i,
  input  wire  [$clog2(DEPTH+1)-1:0]          len_i,
  input  wire  [osq_pkg::WordW-1:0]           prev_i,
  input  wire  [osq_pkg::WordW-1:0]           next_i,
  output logic [osq_pkg::WordW-1:0]           word_o,
  output logic                                match_o,
  output logic [osq_pkg::WordW-1:0]           pick_o
);
  import osq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WordW-1:0] word_q, word_d;
  logic             is_at, after_at, live;

  assign is_at    = (at_i == IW'(IDX));
  assign after_at = (IW'(IDX) > at_i);
  assign live     = (CW'(IDX) < len_i);

  // insert shifts toward the tail, delete pulls from the tail side
  always_comb begin
    word_d = word_q;
    case (ctrl_i.op)
      CELL_INS: begin
        if (is_at) begin
          word_d = ctrl_i.key;
        end else if (after_at) begin
          word_d = prev_i;
        end
      end
      CELL_DEL: begin
        if (is_at || after_at) begin
          word_d = next_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o  = word_q;
  assign match_o = live && (word_q == ctrl_i.key);
  assign pick_o  = is_at ? word_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/osq_scan.sv -----
`default_nettype none

module osq_scan #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [DEPTH-1:0]             hits_i,
  input  wire  [$clog2(DEPTH+1)-1:0]   len_i,
  output logic                         busy_o,
  output logic [$clog2(DEPTH+1)-1:0]   first_o,
  output logic [$clog2(DEPTH+1)-1:0]   last_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0] hits_q, hits_d;
  logic [IW-1:0]    k_q, k_d;
  logic [CW-1:0]    len_q, len_d;
  logic             busy_q, busy_d;
  logic [CW-1:0]    first_q, first_d;
  logic [CW-1:0]    last_q, last_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    cur_pos;

  assign cur_pos = CW'(k_q) + CW'(1);

  // walks the registered hit vector one cell per cycle
  always_comb begin
    hits_d  = hits_q;
    k_d     = k_q;
    len_d   = len_q;
    busy_d  = busy_q;
    first_d = first_q;
    last_d  = last_q;
    cnt_d   = cnt_q;
    if (start_i) begin
      hits_d  = hits_i;
      k_d     = '0;
      len_d   = len_i;
      busy_d  = (len_i != '0);
      first_d = '0;
      last_d  = '0;
      cnt_d   = '0;
    end else if (busy_q) begin
      if (hits_q[k_q]) begin
        cnt_d  = cnt_q + CW'(1);
        last_d = cur_pos;
        if (first_q == '0) begin
          first_d = cur_pos;
        end
      end
      k_d = k_q + IW'(1);
      if (cur_pos == len_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hits_q  <= hits_d;
    k_q     <= k_d;
    len_q   <= len_d;
    first_q <= first_d;
    last_q  <= last_d;
    cnt_q   <= cnt_d;
  end

  assign busy_o  = busy_q;
  assign first_o = first_q;
  assign last_o  = last_q;
  assign count_o = cnt_q;

endmodule

`default_nettype wire
